/* hdl/discrete_pid_duty_regulator_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the PID duty regulator checker
// Clocked, reset-qualified same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef DISCRETE_PID_DUTY_REGULATOR_UNIT_MACROS_SVH
`define DISCRETE_PID_DUTY_REGULATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define DPID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpid check failed");

// Next-cycle implication
`define DPID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpid check failed");

`endif

/* hdl/dpid_pkg.sv */
// ---------------------------------------------------------------------------
// dpid_pkg
// Shared constants and types of the discrete PID duty regulator.
// ---------------------------------------------------------------------------
package dpid_pkg;

  // Parameter defaults
  localparam int SUM_WIDTH_DEF = 32;
  localparam int DUTY_MAX_DEF  = 999;

  // Fixed field widths
  localparam int SP_W    = 8;
  localparam int GAIN_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int ERR_W   = 18;
  localparam int DIFF_W  = 19;
  localparam int DUTY_W  = 10;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 32;

  // Shared multiplier operand widths
  localparam int MA_W   = 34;
  localparam int MB_W   = 25;
  localparam int PROD_W = MA_W + MB_W;

  // Fraction bits of the summed drive
  localparam int FRAC_W = 32;

  // Gain reset values
  localparam logic [GAIN_W-1:0] KP_RST = 32'd1591634;
  localparam logic [GAIN_W-1:0] KI_RST = 32'd4051;
  localparam logic [GAIN_W-1:0] KD_RST = 32'd25268077;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_KD       = 3'd3;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ERR  = 9'b000000010,
    ST_MKP  = 9'b000000100,
    ST_MKD  = 9'b000001000,
    ST_MKIL = 9'b000010000,
    ST_MKIH = 9'b000100000,
    ST_ACCH = 9'b001000000,
    ST_CLIP = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

endpackage

/* hdl/discrete_pid_duty_regulator_unit.sv */
// A request runs through the error, P/D/low-I/high-I multiply, accumulate, clip
// and output states on the single shared 34x25 multiplier and its accumulator.
// in_stall is high while a request is in work; a waiting result does not block
// the next request, only the final load into the output register.
// Reset (rst_n low, synchronous): gains to defaults, setpoint, error history
// and running sum to zero, no result pending.
// ---------------------------------------------------------------------------
// discrete_pid_duty_regulator_unit
// PID regulator turning a Q8.8 temperature sample into a clamped PWM duty,
// using one multiplier under a small sequencer.
// ---------------------------------------------------------------------------
module discrete_pid_duty_regulator_unit
  import dpid_pkg::*;
#(
  parameter int SUM_WIDTH = SUM_WIDTH_DEF,
  parameter int DUTY_MAX  = DUTY_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_A_W-1:0]        cfg_index,
  input  logic [CFG_D_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SAMP_W-1:0]  in_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DUTY_W-1:0]         out_duty,
  output logic                      out_clipped_low,
  output logic                      out_clipped_high
);

  // Sum split for the integral product
  localparam int LO_W  = SUM_WIDTH / 2;
  localparam int HI_W  = SUM_WIDTH - LO_W;
  localparam int ACC_W = SUM_WIDTH + 36;
  localparam int SX_W  = SUM_WIDTH + 2;

  localparam logic signed [SX_W-1:0] SUM_MAX = SX_W'((64'd1 << (SUM_WIDTH - 1)) - 64'd1);
  localparam logic signed [SX_W-1:0] SUM_MIN = -SUM_MAX - SX_W'(1);
  localparam logic [MB_W-1:0]   DM_B = MB_W'(DUTY_MAX);
  localparam logic [DUTY_W-1:0] DM_D = DUTY_W'(DUTY_MAX);

  // Configuration registers
  logic signed [SP_W-1:0]   setpoint_r;
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;

  // Sequencer and datapath registers
  state_t                    state_r, state_nxt;
  logic signed [SAMP_W-1:0]  sample_r;
  logic signed [ERR_W-1:0]   err_r, last_error_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      low_r, high_r;
  logic                      out_valid_r;
  logic [DUTY_W-1:0]         duty_r;
  logic                      clip_low_r, clip_high_r;

  logic signed [ERR_W-1:0]   err_c;
  logic signed [SX_W-1:0]    sum_raw;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]   addend;
  logic                      in_take, out_load, acc_neg, acc_big;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      kp_r       <= KP_RST;
      ki_r       <= KI_RST;
      kd_r       <= KD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETPOINT: setpoint_r <= cfg_wdata[SP_W-1:0];
        REG_KP:       kp_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KI:       ki_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KD:       kd_r       <= cfg_wdata[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Error and saturating running sum
  always_comb begin
    err_c   = {{2{setpoint_r[SP_W-1]}}, setpoint_r, 8'b0}
            - {{(ERR_W-SAMP_W){sample_r[SAMP_W-1]}}, sample_r};
    sum_raw = {{2{sum_r[SUM_WIDTH-1]}}, sum_r}
            + {{(SX_W-ERR_W){err_c[ERR_W-1]}}, err_c}
            + {{(SX_W-ERR_W){last_error_r[ERR_W-1]}}, last_error_r};
    if (sum_raw > SUM_MAX)      sum_sat = SUM_MAX[SUM_WIDTH-1:0];
    else if (sum_raw < SUM_MIN) sum_sat = SUM_MIN[SUM_WIDTH-1:0];
    else                        sum_sat = sum_raw[SUM_WIDTH-1:0];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = {{(MA_W-GAIN_W){kp_r[GAIN_W-1]}}, kp_r};
    mul_b = {{(MB_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    case (state_r)
      ST_MKD: begin
        mul_a = {{(MA_W-GAIN_W){kd_r[GAIN_W-1]}}, kd_r};
        mul_b = {{(MB_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      end
      ST_MKIL: begin
        mul_a = {{(MA_W-GAIN_W){ki_r[GAIN_W-1]}}, ki_r};
        mul_b = {{(MB_W-LO_W){1'b0}}, sum_r[LO_W-1:0]};
      end
      ST_MKIH: begin
        mul_a = {{(MA_W-GAIN_W){ki_r[GAIN_W-1]}}, ki_r};
        mul_b = {{(MB_W-HI_W){sum_r[SUM_WIDTH-1]}}, sum_r[SUM_WIDTH-1:LO_W]};
      end
      ST_CLIP: begin
        // drive is at most one here whenever the result is used
        mul_a = {1'b0, acc_r[FRAC_W:0]};
        mul_b = DM_B;
      end
      default: ;
    endcase
  end

  // Accumulator: high integral part goes in shifted up
  always_comb begin
    addend = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (state_r == ST_ACCH) addend = addend <<< LO_W;
    acc_nxt = acc_r + addend;
  end

  // Clamp decisions on the summed drive (Q.32)
  assign acc_neg = acc_r[ACC_W-1];
  assign acc_big = (|acc_r[ACC_W-2:FRAC_W+1]) || (acc_r[FRAC_W] && (|acc_r[FRAC_W-1:0]));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_MKP;
      ST_MKP:  state_nxt = ST_MKD;
      ST_MKD:  state_nxt = ST_MKIL;
      ST_MKIL: state_nxt = ST_MKIH;
      ST_MKIH: state_nxt = ST_ACCH;
      ST_ACCH: state_nxt = ST_CLIP;
      ST_CLIP: state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Error history and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      sum_r        <= '0;
    end else if (state_r == ST_ERR) begin
      last_error_r <= err_c;
      sum_r        <= sum_sat;
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (in_take) sample_r <= in_sample;
    if (state_r == ST_ERR) begin
      err_r  <= err_c;
      diff_r <= {err_c[ERR_W-1], err_c} - {last_error_r[ERR_W-1], last_error_r};
      acc_r  <= '0;
    end
    if (state_r == ST_MKD || state_r == ST_MKIL || state_r == ST_MKIH ||
        state_r == ST_ACCH) begin
      acc_r <= acc_nxt;
    end
    if (state_r == ST_CLIP) begin
      low_r  <= acc_neg;
      high_r <= !acc_neg && acc_big;
    end
    // scaled duty is held while the result waits for the output register
    if (state_r != ST_OUT) prod_r <= mul_a * mul_b;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      clip_low_r  <= low_r;
      clip_high_r <= high_r;
      if (low_r)       duty_r <= '0;
      else if (high_r) duty_r <= DM_D;
      else             duty_r <= prod_r[FRAC_W +: DUTY_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = duty_r;
  assign out_clipped_low  = clip_low_r;
  assign out_clipped_high = clip_high_r;

endmodule

/* hdl/dpid_checker.sv */
// ---------------------------------------------------------------------------
// dpid_checker
// Port-level checks of the PID duty regulator, bound to its top level.
// ---------------------------------------------------------------------------
`include "discrete_pid_duty_regulator_unit_macros.svh"

module dpid_checker
  import dpid_pkg::*;
#(
  parameter int DUTY_MAX = DUTY_MAX_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [DUTY_W-1:0]        out_duty,
  input logic                     out_clipped_low,
  input logic                     out_clipped_high
);

  localparam logic [DUTY_W-1:0] DM_D = DUTY_W'(DUTY_MAX);

  // Only one clamp can act on a result
  `DPID_ASSERT_IMPL(a_one_clip, out_valid, !(out_clipped_low && out_clipped_high))
  // Clamped results carry the clamp value
  `DPID_ASSERT_IMPL(a_low_zero, out_valid && out_clipped_low, out_duty == '0)
  `DPID_ASSERT_IMPL(a_high_max, out_valid && out_clipped_high, out_duty == DM_D)
  // A taken request keeps the block busy in the next cycle
  `DPID_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)

endmodule

bind discrete_pid_duty_regulator_unit dpid_checker #(.DUTY_MAX(DUTY_MAX)) u_dpid_checker (.*);

/* test/discrete_pid_duty_regulator_unit_tb.sv */
// ---------------------------------------------------------------------------
// discrete_pid_duty_regulator_unit_tb
// Self-checking bench for the PID duty regulator. Samples are pushed through
// the valid/stall request channel while an in-bench model of the controller
// (error history, saturating integrator, exact wide gain products, duty
// scaling and clamping) predicts every result. Results are checked in order,
// field by field, under several register settings and idle patterns.
// ---------------------------------------------------------------------------
module discrete_pid_duty_regulator_unit_tb;
  import dpid_pkg::*;

  localparam int    DRAIN_CYCLES = 12;
  localparam int    CYCLE_LIMIT  = 3000000;
  localparam longint SUM_MAX     = (longint'(1) << (SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_MIN     = -SUM_MAX - 1;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              clipped_low;
    logic              clipped_high;
  } duty_result_t;

  // DUT connections; the bench-driven inputs are known from time zero
  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     cfg_wr_en        = 1'b0;
  logic [CFG_A_W-1:0]       cfg_index        = REG_SETPOINT;
  logic [CFG_D_W-1:0]       cfg_wdata        = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  logic signed [SAMP_W-1:0] in_sample        = '0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  logic [DUTY_W-1:0]        out_duty;
  logic                     out_clipped_low;
  logic                     out_clipped_high;

  // Controller model state
  logic signed [SP_W-1:0]   model_setpoint;
  logic signed [GAIN_W-1:0] model_kp;
  logic signed [GAIN_W-1:0] model_ki;
  logic signed [GAIN_W-1:0] model_kd;
  logic signed [ERR_W-1:0]  model_last_err;
  logic signed [31:0]       model_err_sum;

  duty_result_t expected_duty_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_low         = 0;
  int n_high        = 0;
  int n_cfg_writes  = 0;
  int cycle_count   = 0;

  discrete_pid_duty_regulator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_clipped_low  (out_clipped_low),
    .out_clipped_high (out_clipped_high)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    duty_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_clipped_low)  n_low++;
      if (out_clipped_high) n_high++;
      if (expected_duty_q.size() == 0) begin
        $display("%0t: result with nothing expected: duty %0d low %0b high %0b",
                 $realtime, out_duty, out_clipped_low, out_clipped_high);
        fail_count++;
      end else begin
        want = expected_duty_q.pop_front();
        if (out_duty !== want.duty) begin
          $display("%0t: duty mismatch: expected %0d, actual %0d",
                   $realtime, want.duty, out_duty);
          fail_count++;
        end
        if (out_clipped_low !== want.clipped_low) begin
          $display("%0t: clipped_low mismatch: expected %0b, actual %0b",
                   $realtime, want.clipped_low, out_clipped_low);
          fail_count++;
        end
        if (out_clipped_high !== want.clipped_high) begin
          $display("%0t: clipped_high mismatch: expected %0b, actual %0b",
                   $realtime, want.clipped_high, out_clipped_high);
          fail_count++;
        end
      end
    end
  end

  // Reset values of the model
  function automatic void reset_model();
    model_setpoint = '0;
    model_kp       = KP_RST;
    model_ki       = KI_RST;
    model_kd       = KD_RST;
    model_last_err = '0;
    model_err_sum  = '0;
  endfunction

  // Register write as the block sees it; upper bits are dropped
  function automatic void apply_register(input logic [CFG_A_W-1:0] idx,
                                         input logic [CFG_D_W-1:0] data);
    case (idx)
      REG_SETPOINT: model_setpoint = data[SP_W-1:0];
      REG_KP:       model_kp = data[GAIN_W-1:0];
      REG_KI:       model_ki = data[GAIN_W-1:0];
      REG_KD:       model_kd = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // One control step: error, saturating integrator, exact PID sum, clamp
  function automatic duty_result_t predict_duty(input logic signed [SAMP_W-1:0] s);
    longint                err;
    longint                acc;
    longint                diff;
    logic signed [127:0]   term;
    logic signed [127:0]   drive;
    logic signed [127:0]   scaled;
    logic signed [127:0]   ceiling;
    duty_result_t          r;
    err = longint'(model_setpoint) * 256 - longint'(s);
    acc = longint'(model_err_sum) + err + longint'(model_last_err);
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    diff = err - longint'(model_last_err);
    term  = model_kp;
    drive = term * err;
    term  = model_ki;
    drive = drive + term * acc;
    term  = model_kd;
    drive = drive + term * diff;
    model_err_sum  = acc[31:0];
    model_last_err = err[ERR_W-1:0];
    r = '0;
    ceiling = DUTY_MAX_DEF;
    ceiling = ceiling <<< FRAC_W;
    if (drive < 0) begin
      r.clipped_low = 1'b1;
    end else begin
      scaled = drive * DUTY_MAX_DEF;
      if (scaled > ceiling) begin
        r.duty         = DUTY_W'(DUTY_MAX_DEF);
        r.clipped_high = 1'b1;
      end else begin
        r.duty = scaled[FRAC_W +: DUTY_W];
      end
    end
    return r;
  endfunction

  // Send one sample request; valid stays high unless a gap is drawn
  task automatic send_sample(input logic signed [SAMP_W-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_duty_q.push_back(predict_duty(s));
    n_requests++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_A_W-1:0] idx,
                           input logic [CFG_D_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_register(idx, data);
    n_cfg_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Writes to unused indexes must leave every register alone
  task automatic write_unused_indexes();
    for (int i = REG_KD + 1; i < (1 << CFG_A_W); i++) begin
      cfg_write(CFG_A_W'(i), $urandom());
    end
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(input int span_bits);
    int v;
    if ($urandom_range(9) == 0) return $urandom();
    v = int'($urandom_range((1 << span_bits) - 1)) - (1 << (span_bits - 1));
    return v;
  endfunction

  // Mostly close to the setpoint so the duty lands inside its range
  function automatic logic signed [SAMP_W-1:0] pick_sample();
    int base;
    int v;
    int r;
    base = int'(model_setpoint) * 256;
    r = $urandom_range(99);
    if (r < 60)      v = base + int'($urandom_range(4096)) - 2048;
    else if (r < 85) v = base + int'($urandom_range(32768)) - 16384;
    else             return SAMP_W'($urandom());
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return SAMP_W'(v);
  endfunction

  // Reset gains, zero and extreme samples
  task automatic test_reset_defaults();
    send_sample(16'sd0);
    send_sample(-16'sd256);
    send_sample(16'sd256);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    settle();
  endtask

  // Unit proportional gain: exact top of range, fraction above it, tiny negative
  task automatic test_clamp_edges();
    cfg_write(REG_SETPOINT, '0);
    cfg_write(REG_KP, 32'h0100_0000);
    cfg_write(REG_KI, '0);
    cfg_write(REG_KD, '0);
    send_sample(-16'sd256);
    send_sample(-16'sd257);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    settle();
    cfg_write(REG_KP, 32'h0100_0001);
    send_sample(-16'sd256);
    settle();
  endtask

  // Register extremes, ignored upper bits and unused indexes
  task automatic test_register_extremes();
    cfg_write(REG_SETPOINT, 32'hFFFF_FF80);
    cfg_write(REG_KP, 32'h7FFF_FFFF);
    cfg_write(REG_KI, 32'h8000_0000);
    cfg_write(REG_KD, '0);
    write_unused_indexes();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    settle();
    cfg_write(REG_SETPOINT, 32'h1234_567F);
    cfg_write(REG_KP, 32'h8000_0000);
    cfg_write(REG_KI, 32'h7FFF_FFFF);
    cfg_write(REG_KD, 32'h8000_0000);
    send_sample(16'sh8000);
    send_sample(16'shAAAA);
    send_sample(16'sh7FFF);
    settle();
    cfg_write(REG_KD, 32'h7FFF_FFFF);
    cfg_write(REG_KI, '0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    settle();
  endtask

  // Random traffic in segments, each under a fresh register setting
  task automatic test_random_traffic(input int segments, input int per_segment,
                                     input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int seg = 0; seg < segments; seg++) begin
      settle();
      cfg_write(REG_SETPOINT, $urandom());
      cfg_write(REG_KP, pick_gain(26));
      cfg_write(REG_KI, pick_gain(16));
      cfg_write(REG_KD, pick_gain(27));
      if ($urandom_range(3) == 0) write_unused_indexes();
      for (int n = 0; n < per_segment; n++) send_sample(pick_sample());
    end
    settle();
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_clamp_edges();
    test_register_extremes();
    test_random_traffic(4, 117, 36, 52);
    test_random_traffic(4, 117, 52, 36);
    test_random_traffic(4, 117, 0, 0);

    settle();
    $display("Run covered %0d sample requests and %0d duty results",
             n_requests, n_results);
    $display("(%0d clipped low, %0d clipped high) over %0d register writes and three idle patterns.",
             n_low, n_high, n_cfg_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/dpid_pkg.sv
hdl/discrete_pid_duty_regulator_unit.sv
hdl/dpid_checker.sv
test/discrete_pid_duty_regulator_unit_tb.sv
